// ===== sv/hct_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hct_pkg
// Shared types and constants for the HTML character class tokenizer.
// ----------------------------------------------------------------------------
package hct_pkg;

  localparam int CHAR_BITS = 8;

  typedef logic [CHAR_BITS-1:0] char_t;

  // Parsing mode carried across lines
  typedef enum logic [2:0] {
    MODE_NORMAL  = 3'd0,
    MODE_COMMENT = 3'd1,
    MODE_TAG     = 3'd2,
    MODE_ATTR    = 3'd3,
    MODE_VALUE   = 3'd4
  } mode_t;

  // Character class codes on the result port
  typedef enum logic [2:0] {
    CL_NORMAL  = 3'd0,
    CL_ENTITY  = 3'd1,
    CL_TAG     = 3'd2,
    CL_COMMENT = 3'd3,
    CL_ATTR    = 3'd4,
    CL_VALUE   = 3'd5
  } class_t;

  typedef enum logic [1:0] {
    QUOTE_NONE   = 2'd0,
    QUOTE_DOUBLE = 2'd1,
    QUOTE_SINGLE = 2'd2
  } quote_t;

  localparam char_t CH_LT     = char_t'(8'h3C); // '<'
  localparam char_t CH_GT     = char_t'(8'h3E); // '>'
  localparam char_t CH_BANG   = char_t'(8'h21); // '!'
  localparam char_t CH_DASH   = char_t'(8'h2D); // '-'
  localparam char_t CH_AMP    = char_t'(8'h26); // '&'
  localparam char_t CH_SEMI   = char_t'(8'h3B); // ';'
  localparam char_t CH_EQ     = char_t'(8'h3D); // '='
  localparam char_t CH_SLASH  = char_t'(8'h2F); // '/'
  localparam char_t CH_SPACE  = char_t'(8'h20); // ' '
  localparam char_t CH_DQUOTE = char_t'(8'h22); // '"'
  localparam char_t CH_SQUOTE = char_t'(8'h27); // '\''
  localparam char_t CH_H      = char_t'(8'h68);
  localparam char_t CH_T      = char_t'(8'h74);
  localparam char_t CH_M      = char_t'(8'h6D);
  localparam char_t CH_L      = char_t'(8'h6C);

  localparam int WIN_DEPTH = 4;
  localparam int JQ_DEPTH  = 4;
  localparam int RQ_DEPTH  = 2;

  // One classification job: a character plus the lookahead verdicts at its place
  typedef struct packed {
    char_t ch;
    logic  m_open;   // "<!--" starts here
    logic  m_close;  // "-->" starts here
    logic  m_html;   // "html" starts here
    logic  last;     // last character of the line
  } job_t;

  typedef struct packed {
    logic [7:0] ch;
    class_t     cls;
    logic       line_end;
  } result_t;

  // Queue status between producer and consumer
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== sv/html_char_class_tokenizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// html_char_class_tokenizer
// Tags each HTML character as normal, entity, tag, comment, attribute or
// value, using a three-character lookahead within the line.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake     Payload
//  --------  ------------  -----------------------------------
//  input     push / full   in_char, in_line_end
//  result    empty / pop   out_char, out_class, out_line_end
//
// One character per cycle is taken while the queues flow. A character that
// ends a line with n characters (1..4) in the window keeps full high while
// the window drains the other n-1 jobs into the job queue, one job a cycle
// while that queue has room. Results lag by three characters within a line;
// each job enters the job queue when issued, and the classifier moves it
// into the result queue while that has room; its head drives the ports.
// Synchronous reset clears the window fill, mode state and both queues.
// Either side may stall independently; the 4-entry job queue decouples
// window and classifier, the 2-entry result queue classifier and reader.
//
module html_char_class_tokenizer (
  input  logic       clk,
  input  logic       rst,
  // character input
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_char,
  input  logic       in_line_end,
  // classified output
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char,
  output logic [2:0] out_class,
  output logic       out_line_end
);
  import hct_pkg::*;

  logic      job_valid;
  job_t      front_job;
  job_t      head_job;
  logic      job_pop;
  q_status_t jq_status;
  result_t   result;

  // Window and lookahead matching
  hct_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .in_char    (char_t'(in_char)),
    .in_line_end(in_line_end),
    .full       (full),
    .jq_full    (jq_status.full),
    .job_valid  (job_valid),
    .job        (front_job)
  );

  // Jobs waiting for the classifier
  hct_job_queue u_job_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (job_valid),
    .wr_job (front_job),
    .rd_en  (job_pop),
    .rd_job (head_job),
    .status (jq_status)
  );

  // Mode machine and result queue
  hct_back u_back (
    .clk      (clk),
    .rst      (rst),
    .jq_status(jq_status),
    .job      (head_job),
    .job_pop  (job_pop),
    .result   (result),
    .empty    (empty),
    .pop      (pop)
  );

  assign out_char     = result.ch;
  assign out_class    = result.cls;
  assign out_line_end = result.line_end;

endmodule

// ===== sv/hct_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hct_front
// Lookahead window: takes characters, evaluates pattern matches and issues
// classification jobs; drains the held characters at each line end.
// ----------------------------------------------------------------------------
module hct_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  hct_pkg::char_t    in_char,
  input  logic              in_line_end,
  output logic              full,
  input  logic              jq_full,
  output logic              job_valid,
  output hct_pkg::job_t     job
);
  import hct_pkg::*;

  char_t      win [WIN_DEPTH];
  logic [2:0] fill;
  logic       draining;
  logic [1:0] dpos;

  char_t      win_n [WIN_DEPTH];
  logic [2:0] fill_n;
  logic       accept;

  char_t      v_win [WIN_DEPTH];
  logic [2:0] v_fill;
  logic [1:0] v_pos;
  logic       drain_last;

  assign full   = draining | jq_full;
  assign accept = push & ~full;
  assign fill_n = fill + 3'd1;

  always_comb begin
    for (int i = 0; i < WIN_DEPTH; i++) begin
      win_n[i] = (fill[1:0] == 2'(i)) ? in_char : win[i];
    end
  end

  // Window view for the job issued this cycle
  always_comb begin
    if (draining) begin
      v_win  = win;
      v_fill = fill;
      v_pos  = dpos;
    end else begin
      v_win  = win_n;
      v_fill = fill_n;
      v_pos  = 2'd0;
    end
  end

  assign drain_last = (({1'b0, dpos} + 3'd1) == fill);

  always_comb begin
    job.ch     = v_win[v_pos];
    job.m_open = (v_pos == 2'd0) && (v_fill == 3'd4) &&
                 (v_win[0] == CH_LT) && (v_win[1] == CH_BANG) &&
                 (v_win[2] == CH_DASH) && (v_win[3] == CH_DASH);
    job.m_html = (v_pos == 2'd0) && (v_fill == 3'd4) &&
                 (v_win[0] == CH_H) && (v_win[1] == CH_T) &&
                 (v_win[2] == CH_M) && (v_win[3] == CH_L);
    job.m_close = ((v_pos == 2'd0) && (v_fill >= 3'd3) &&
                   (v_win[0] == CH_DASH) && (v_win[1] == CH_DASH) &&
                   (v_win[2] == CH_GT)) ||
                  ((v_pos == 2'd1) && (v_fill == 3'd4) &&
                   (v_win[1] == CH_DASH) && (v_win[2] == CH_DASH) &&
                   (v_win[3] == CH_GT));
    if (draining) begin
      job.last  = drain_last;
      job_valid = ~jq_full;
    end else begin
      job.last  = in_line_end && (fill_n == 3'd1);
      job_valid = accept && (in_line_end || (fill_n == 3'd4));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= 3'd0;
      draining <= 1'b0;
      dpos     <= 2'd0;
    end else if (draining) begin
      if (~jq_full) begin
        dpos <= dpos + 2'd1;
        if (drain_last) begin
          draining <= 1'b0;
          fill     <= 3'd0;
        end
      end
    end else if (accept) begin
      if (in_line_end) begin
        if (fill_n == 3'd1) begin
          fill <= 3'd0;
        end else begin
          fill     <= fill_n;
          draining <= 1'b1;
          dpos     <= 2'd1;
        end
      end else if (fill_n == 3'd4) begin
        fill <= 3'd3;
      end else begin
        fill <= fill_n;
      end
    end
  end

  // Window payload
  always_ff @(posedge clk) begin
    if (~draining && accept) begin
      if (~in_line_end && (fill_n == 3'd4)) begin
        for (int i = 0; i < WIN_DEPTH - 1; i++) begin
          win[i] <= win_n[i+1];
        end
        win[WIN_DEPTH-1] <= win_n[WIN_DEPTH-1];
      end else begin
        win <= win_n;
      end
    end
  end

endmodule

// ===== sv/hct_job_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hct_job_queue
// Short FIFO of classification jobs between the window and the classifier.
// ----------------------------------------------------------------------------
module hct_job_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  hct_pkg::job_t      wr_job,
  input  logic               rd_en,
  output hct_pkg::job_t      rd_job,
  output hct_pkg::q_status_t status
);
  import hct_pkg::*;

  job_t       mem [JQ_DEPTH];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       do_wr;
  logic       do_rd;

  assign status.full  = (count == 3'(JQ_DEPTH));
  assign status.empty = (count == 3'd0);
  assign do_wr        = wr_en & ~status.full;
  assign do_rd        = rd_en & ~status.empty;
  assign rd_job       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 2'd1;
      if (do_rd) rd_ptr <= rd_ptr + 2'd1;
      if (do_wr && !do_rd) begin
        count <= count + 3'd1;
      end else if (!do_wr && do_rd) begin
        count <= count - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= wr_job;
  end

endmodule

// ===== sv/hct_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hct_back
// Classifier: applies the mode machine to each job and queues the results.
// ----------------------------------------------------------------------------
module hct_back (
  input  logic               clk,
  input  logic               rst,
  input  hct_pkg::q_status_t jq_status,
  input  hct_pkg::job_t      job,
  output logic               job_pop,
  output hct_pkg::result_t   result,
  output logic               empty,
  input  logic               pop
);
  import hct_pkg::*;

  mode_t      mode, mode_next;
  logic       entity, entity_next;
  quote_t     quote, quote_next;
  logic       vqs, vqs_next;
  logic [1:0] skip, skip_next;
  class_t     cls;

  result_t    rq [RQ_DEPTH];
  logic       rq_wr_ptr;
  logic       rq_rd_ptr;
  logic [1:0] rq_count;
  logic       rq_full;
  logic       rq_rd;

  assign rq_full = (rq_count == 2'(RQ_DEPTH));
  assign job_pop = ~jq_status.empty & ~rq_full;
  assign empty   = (rq_count == 2'd0);
  assign rq_rd   = pop & ~empty;
  assign result  = rq[rq_rd_ptr];

  always_comb begin
    mode_next   = mode;
    entity_next = entity;
    quote_next  = quote;
    vqs_next    = vqs;
    skip_next   = skip;
    cls         = CL_NORMAL;
    if (skip != 2'd0) begin
      skip_next = skip - 2'd1;
      cls       = CL_COMMENT;
    end else begin
      unique case (mode)
        MODE_COMMENT: begin
          cls = CL_COMMENT;
          if (job.m_close) begin
            skip_next = 2'd2;
            mode_next = MODE_NORMAL;
          end
        end
        MODE_TAG: begin
          cls = CL_TAG;
          if (quote == QUOTE_NONE) begin
            if (job.ch == CH_DQUOTE) begin
              quote_next = QUOTE_DOUBLE;
            end else if (job.ch == CH_SQUOTE) begin
              quote_next = QUOTE_SINGLE;
            end else if (job.ch == CH_GT) begin
              mode_next = MODE_NORMAL;
            end else if (job.ch == CH_SPACE) begin
              mode_next = MODE_ATTR;
              cls       = CL_ATTR;
            end
          end else if ((quote == QUOTE_DOUBLE && job.ch == CH_DQUOTE) ||
                       (quote == QUOTE_SINGLE && job.ch == CH_SQUOTE)) begin
            quote_next = QUOTE_NONE;
          end
        end
        MODE_ATTR: begin
          cls = CL_ATTR;
          if (job.ch == CH_EQ) begin
            mode_next = MODE_VALUE;
            vqs_next  = 1'b0;
          end else if (job.ch == CH_GT) begin
            mode_next = MODE_NORMAL;
          end else if (job.ch == CH_SLASH || job.m_html) begin
            // back to tag mode; the character itself is tag
            mode_next  = MODE_TAG;
            quote_next = QUOTE_NONE;
            cls        = CL_TAG;
          end
        end
        MODE_VALUE: begin
          cls = CL_VALUE;
          if (job.ch == CH_DQUOTE) begin
            if (vqs) begin
              vqs_next   = 1'b0;
              mode_next  = MODE_TAG;
              quote_next = QUOTE_NONE;
            end else begin
              vqs_next = 1'b1;
            end
          end
        end
        default: begin
          if (entity) begin
            if (job.ch == CH_SEMI) begin
              entity_next = 1'b0;
              cls         = CL_NORMAL;
            end else begin
              cls = CL_ENTITY;
            end
          end else if (job.ch == CH_LT) begin
            if (job.m_open) begin
              mode_next = MODE_COMMENT;
              cls       = CL_COMMENT;
            end else begin
              mode_next  = MODE_TAG;
              quote_next = QUOTE_NONE;
              cls        = CL_TAG;
            end
          end else if (job.ch == CH_AMP) begin
            entity_next = 1'b1;
            cls         = CL_ENTITY;
          end
        end
      endcase
    end
    // line end clears the per-line state, mode carries on
    if (job.last) begin
      entity_next = 1'b0;
      quote_next  = QUOTE_NONE;
      vqs_next    = 1'b0;
      skip_next   = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_NORMAL;
      entity <= 1'b0;
      quote  <= QUOTE_NONE;
      vqs    <= 1'b0;
      skip   <= 2'd0;
    end else if (job_pop) begin
      mode   <= mode_next;
      entity <= entity_next;
      quote  <= quote_next;
      vqs    <= vqs_next;
      skip   <= skip_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rq_wr_ptr <= 1'b0;
      rq_rd_ptr <= 1'b0;
      rq_count  <= 2'd0;
    end else begin
      if (job_pop) rq_wr_ptr <= ~rq_wr_ptr;
      if (rq_rd)   rq_rd_ptr <= ~rq_rd_ptr;
      if (job_pop && !rq_rd) begin
        rq_count <= rq_count + 2'd1;
      end else if (!job_pop && rq_rd) begin
        rq_count <= rq_count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      rq[rq_wr_ptr].ch       <= job.ch[7:0];
      rq[rq_wr_ptr].cls      <= cls;
      rq[rq_wr_ptr].line_end <= job.last;
    end
  end

endmodule
